### src/akf_pkg.sv
`default_nettype none
package akf_pkg;

  // Fixed-point format of estimate, covariance and gain.
  localparam int FRAC_BITS = 16;

  // Field and state widths.
  localparam int READ_W = 16;
  localparam int EST_W = 32;
  localparam int GAIN_W = 17;
  localparam int COV_W = 26;
  localparam int P_W = 27;
  localparam int DEN_W = 28;
  localparam int DIFF_W = 33;
  localparam int NS_W = 24;
  localparam int ME_W = 25;
  localparam int SPAN_W = 16;

  // Shared serial units.
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int DIV_R_W = 29;
  localparam int DIV_D_W = 43;
  localparam int DIV_V_W = 28;
  localparam int CNT_W = 6;

  // Ports.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_SCALE,
    REG_MEAS_ERROR,
    REG_SENSOR_SPAN,
    REG_INIT_EST
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QSQ,
    ST_NSMUL,
    ST_KDIV,
    ST_EMUL,
    ST_PMUL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### src/adaptive_scalar_kalman_filter.sv
`default_nettype none
// One bit-serial divider (33 and 17 steps) and one bit-serial multiplier (32, 24, 17 and 17
// steps) run in turn between an accepted reading and its result item in the output register.
// A new reading is taken only once the previous result item is loaded into the output register;
// the calculation only waits in its last state while the previous result item has not been taken.
// Reset (synchronous, active high) restores the configuration defaults and clears the state.
module adaptive_scalar_kalman_filter (
  input  logic                            clk,
  input  logic                            rst,
  // reading [15:0]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [akf_pkg::S_TDATA_W-1:0]   s_tdata,
  // estimate [31:0], gain [48:32], zero fill [55:49]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [akf_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [akf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [akf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import akf_pkg::*;

  state_t state, state_next;
  logic   go;

  // Configuration.
  logic [NS_W-1:0]   noise_scale;
  logic [ME_W-1:0]   meas_error;
  logic [SPAN_W-1:0] sensor_span;
  logic [SPAN_W-1:0] span_eff;

  // Filter state.
  logic signed [EST_W-1:0] prev_estimate;
  logic signed [EST_W-1:0] last_output;
  logic [COV_W-1:0]        covariance;

  // Working registers.
  logic [DIFF_W-1:0]       dmag;
  logic [DIFF_W-1:0]       emag;
  logic                    eneg;
  logic [EST_W-1:0]        q;
  logic [MUL_A_W-1:0]      sq;
  logic [P_W-1:0]          p;
  logic [GAIN_W-1:0]       k;
  logic signed [EST_W-1:0] x;

  // Combinational helpers.
  logic signed [EST_W-1:0]  rd_fx;
  logic signed [DIFF_W-1:0] dd;
  logic signed [DIFF_W-1:0] ed;
  logic [DEN_W-1:0]         den;
  logic [GAIN_W-1:0]        delta;
  logic [DIFF_W-1:0]        mag;
  logic signed [EST_W+2:0]  xsum;
  logic [P_W-1:0]           np;
  logic                     in_acc;
  logic                     out_load;

  // Serial unit interface.
  logic                         div_start, div_done;
  logic [DIV_R_W-1:0]           div_rem_init;
  logic [DIV_D_W-1:0]           div_dividend;
  logic [DIV_V_W-1:0]           div_divisor;
  logic [CNT_W-1:0]             div_iters;
  logic [DIV_D_W-1:0]           div_quo;
  logic                         mul_start, mul_done;
  logic [MUL_A_W-1:0]           mul_a;
  logic [MUL_B_W-1:0]           mul_b;
  logic [CNT_W-1:0]             mul_iters;
  logic [MUL_A_W+MUL_B_W-1:0]   mul_prod;

  akf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  akf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .iters   (mul_iters),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Arithmetic around the serial units.
  always_comb begin
    rd_fx    = EST_W'($signed(s_tdata)) <<< FRAC_BITS;
    dd       = DIFF_W'(last_output) - DIFF_W'(rd_fx);
    ed       = DIFF_W'(rd_fx) - DIFF_W'(prev_estimate);
    span_eff = (sensor_span == '0) ? SPAN_W'(1) : sensor_span;
    den      = {1'b0, p} + DEN_W'(meas_error);
    // A scaled product of 2^32 or more is at least one after the fraction shift.
    delta    = (mul_prod[79:40] != '0) ? GAIN_ONE : {1'b0, mul_prod[39:24]};
    mag      = mul_prod[63:31];
    xsum     = eneg ? (35'(prev_estimate) - $signed({2'b0, mag}))
                    : (35'(prev_estimate) + $signed({2'b0, mag}));
    np       = mul_prod[57:31];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_QDIV;
      ST_QDIV:  if (div_done) state_next = ST_QSQ;
      ST_QSQ:   if (mul_done) state_next = ST_NSMUL;
      ST_NSMUL: if (mul_done) state_next = ST_KDIV;
      ST_KDIV:  if (div_done) state_next = ST_EMUL;
      ST_EMUL:  if (mul_done) state_next = ST_PMUL;
      ST_PMUL:  if (mul_done) state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: launches and operand selection.
  always_comb begin
    s_tready     = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_rem_init = '0;
    div_dividend = '0;
    div_divisor  = '0;
    div_iters    = '0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_iters    = '0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_QDIV: begin
        div_start    = go;
        div_dividend = {dmag, 10'b0};
        div_divisor  = DIV_V_W'(span_eff);
        div_iters    = CNT_W'(DIFF_W);
      end
      ST_QSQ: begin
        mul_start = go;
        mul_a     = MUL_A_W'(q);
        mul_b     = q;
        mul_iters = CNT_W'(MUL_B_W);
      end
      ST_NSMUL: begin
        mul_start = go;
        mul_a     = sq;
        mul_b     = MUL_B_W'(noise_scale);
        mul_iters = CNT_W'(NS_W);
      end
      ST_KDIV: begin
        // Start with half of P in the remainder so the first step yields the integer bit.
        div_start    = go;
        div_rem_init = DIV_R_W'(p[P_W-1:1]);
        div_dividend = {p[0], 42'b0};
        div_divisor  = den;
        div_iters    = CNT_W'(GAIN_W);
      end
      ST_EMUL: begin
        mul_start = go;
        mul_a     = MUL_A_W'(emag);
        mul_b     = MUL_B_W'(k);
        mul_iters = CNT_W'(GAIN_W);
      end
      ST_PMUL: begin
        mul_start = go;
        mul_a     = MUL_A_W'(p);
        mul_b     = MUL_B_W'(GAIN_ONE - k);
        mul_iters = CNT_W'(GAIN_W);
      end
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_acc = s_tvalid && s_tready;

  // State register; go marks the first cycle in each state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= state_next != state;
    end
  end

  // Configuration registers and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_scale   <= NS_W'(65536);
      meas_error    <= ME_W'(65536);
      sensor_span   <= SPAN_W'(65535);
      prev_estimate <= '0;
      last_output   <= '0;
      covariance    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_NOISE_SCALE: noise_scale   <= cfg_data[NS_W-1:0];
          REG_MEAS_ERROR:  meas_error    <= cfg_data[ME_W-1:0];
          REG_SENSOR_SPAN: sensor_span   <= cfg_data[SPAN_W-1:0];
          REG_INIT_EST:    prev_estimate <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (state == ST_PMUL && mul_done) begin
        covariance    <= np[P_W-1] ? {COV_W{1'b1}} : np[COV_W-1:0];
        prev_estimate <= x;
        last_output   <= x;
      end
    end
  end

  // Working registers, loaded as a reading is accepted and as each step of the calculation completes.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dmag <= dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
      emag <= ed[DIFF_W-1] ? DIFF_W'(-ed) : DIFF_W'(ed);
      eneg <= ed[DIFF_W-1];
    end
    if (state == ST_QDIV && div_done) begin
      q <= div_quo[EST_W] ? {EST_W{1'b1}} : div_quo[EST_W-1:0];
    end
    if (state == ST_QSQ && mul_done) begin
      sq <= mul_prod[63:16];
    end
    if (state == ST_NSMUL && mul_done) begin
      p <= {1'b0, covariance} + P_W'(delta);
    end
    if (state == ST_KDIV && div_done) begin
      k <= (den == '0) ? '0 : div_quo[GAIN_W-1:0];
    end
    if (state == ST_EMUL && mul_done) begin
      if (xsum > 35'sh07FFFFFFF) begin
        x <= 32'sh7FFFFFFF;
      end else if (xsum < -35'sh080000000) begin
        x <= 32'sh80000000;
      end else begin
        x <= xsum[EST_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, k, x};
    end
  end

endmodule
`default_nettype wire

### src/akf_div.sv
`default_nettype none
module akf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [akf_pkg::DIV_R_W-1:0]  rem_init,
  input  logic [akf_pkg::DIV_D_W-1:0]  dividend,
  input  logic [akf_pkg::DIV_V_W-1:0]  divisor,
  input  logic [akf_pkg::CNT_W-1:0]    iters,
  output logic                         done,
  output logic [akf_pkg::DIV_D_W-1:0]  quotient
);
  import akf_pkg::*;

  logic [DIV_R_W-1:0] rem;
  logic [DIV_D_W-1:0] dvd;
  logic [DIV_V_W-1:0] vsr;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIV_R_W-1:0] trial;
  logic [DIV_R_W-1:0] diff;
  logic               fits;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem[DIV_R_W-2:0], dvd[DIV_D_W-1]};
    fits  = trial >= {1'b0, vsr};
    diff  = trial - {1'b0, vsr};
  end

  // Iteration counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      dvd      <= dividend;
      vsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? diff : trial;
      dvd      <= {dvd[DIV_D_W-2:0], 1'b0};
      quotient <= {quotient[DIV_D_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### src/akf_mul.sv
`default_nettype none
module akf_mul (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [akf_pkg::MUL_A_W-1:0]           a,
  input  logic [akf_pkg::MUL_B_W-1:0]           b,
  input  logic [akf_pkg::CNT_W-1:0]             iters,
  output logic                                  done,
  output logic [akf_pkg::MUL_A_W+akf_pkg::MUL_B_W-1:0] product
);
  import akf_pkg::*;

  logic [MUL_A_W-1:0] areg;
  logic [MUL_A_W-1:0] hi;
  logic [MUL_B_W-1:0] lo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [MUL_A_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set.
  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, areg} : '0);
  end

  assign product = {hi, lo};

  // Iteration counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial product shifts right one bit per cycle while busy; used multiplier bits drop out below.
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      hi   <= '0;
      lo   <= b;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule
`default_nettype wire

### sim/adaptive_scalar_kalman_filter_tb.sv
`timescale 1ns / 1ps
module adaptive_scalar_kalman_filter_tb;
  import akf_pkg::*;

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] COV_LIMIT = (64'd1 << COV_W) - 1;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;
  } filter_out_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the filter state and its registers.
  logic [NS_W-1:0] scale_q;
  logic [ME_W-1:0] meas_var_q;
  logic [SPAN_W-1:0] span_q;
  logic signed [EST_W-1:0] est_prev_q;
  logic signed [EST_W-1:0] out_last_q;
  logic [COV_W-1:0] cov_q;

  filter_out_t pending_results[$];
  int mismatches;
  bit ready_steady;

  adaptive_scalar_kalman_filter uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Works out the result of one reading and advances the shadow state.
  function automatic filter_out_t filter_step(input logic signed [READ_W-1:0] reading);
    longint rd;
    longint e;
    longint x;
    logic [63:0] span;
    logic [63:0] q;
    logic [63:0] sq;
    logic [63:0] delta;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] k;
    logic [63:0] adj;
    logic [63:0] np;
    logic [127:0] prod;
    filter_out_t r;
    rd = longint'(reading) * 65536;
    span = (span_q == 0) ? 64'd1 : 64'(span_q);
    q = mag64(longint'(out_last_q) - rd) / span;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    sq = (q * q) >> FRAC_BITS;
    prod = 128'(sq) * 128'(scale_q);
    if (prod[127:64] != 0) delta = ONE_Q;
    else delta = prod[63:0] >> FRAC_BITS;
    if (delta > ONE_Q) delta = ONE_Q;
    p = 64'(cov_q) + delta;
    den = p + 64'(meas_var_q);
    k = (den != 0) ? (p << FRAC_BITS) / den : 64'd0;
    if (k > ONE_Q) k = ONE_Q;
    e = rd - longint'(est_prev_q);
    adj = (mag64(e) * k) >> FRAC_BITS;
    x = (e < 0) ? longint'(est_prev_q) - longint'(adj) : longint'(est_prev_q) + longint'(adj);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    np = ((ONE_Q - k) * p) >> FRAC_BITS;
    if (np > COV_LIMIT) np = COV_LIMIT;
    cov_q = np[COV_W-1:0];
    est_prev_q = x[EST_W-1:0];
    out_last_q = x[EST_W-1:0];
    r.estimate = x[EST_W-1:0];
    r.gain = k[GAIN_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  // Output back-pressure, with stretches where the sink is always ready.
  initial begin
    m_tready = 1'b0;
    ready_steady = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) ready_steady = !ready_steady;
      if (ready_steady) m_tready <= 1'b1;
      else if ($urandom_range(0, 9) < 6) m_tready <= 1'b1;
      else m_tready <= 1'b0;
      if (!ready_steady && !m_tready && $urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // Compares each result item with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Unexpected result item: %h", m_tdata);
      end else begin
        filter_out_t want;
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.estimate || m_tdata[48:32] !== want.gain) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("Mismatch: estimate exp %h got %h, gain exp %h got %h",
                     want.estimate, m_tdata[31:0], want.gain, m_tdata[48:32]);
        end
      end
    end
  end

  // Offers one reading and records its expected result once accepted.
  // The wait before valid is raised is never skipped, so valid is never dropped and raised at the same edge.
  task automatic send_reading(input logic signed [READ_W-1:0] reading);
    repeat (1 + pick_gap()) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= reading;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(filter_step(reading));
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only once every result has come back.
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_NOISE_SCALE: scale_q = value[NS_W-1:0];
      REG_MEAS_ERROR: meas_var_q = value[ME_W-1:0];
      REG_SENSOR_SPAN: span_q = value[SPAN_W-1:0];
      REG_INIT_EST: est_prev_q = value;
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    send_reading(16'sd0);
    send_reading(16'sd32767);
    send_reading(-16'sd32768);
    send_reading(-16'sd1);
    send_reading(16'sd1);
  endtask

  task automatic test_initial_estimate();
    write_reg(REG_INIT_EST, 32'h7FFF_FFFF);
    send_reading(16'sd32767);
    write_reg(REG_INIT_EST, 32'h8000_0000);
    send_reading(-16'sd32768);
    write_reg(REG_INIT_EST, 32'h0000_0000);
    send_reading(16'sd100);
  endtask

  task automatic test_special_cases();
    // A zero span behaves like a span of one; with full scale the noise term saturates.
    write_reg(REG_SENSOR_SPAN, 32'd0);
    write_reg(REG_NOISE_SCALE, 32'hFF_FFFF);
    send_reading(16'sd32767);
    send_reading(-16'sd32768);
    write_reg(REG_SENSOR_SPAN, 32'd1);
    send_reading(16'sd32767);
    // No process noise and no sensor variance drive the covariance to zero, then give a zero denominator.
    write_reg(REG_NOISE_SCALE, 32'd0);
    write_reg(REG_MEAS_ERROR, 32'd0);
    send_reading(16'sd5);
    send_reading(-16'sd5);
    write_reg(REG_MEAS_ERROR, 32'h1FF_FFFF);
    write_reg(REG_NOISE_SCALE, 32'd1);
    write_reg(REG_SENSOR_SPAN, 32'hFFFF);
    send_reading(16'sd1234);
    write_reg(REG_MEAS_ERROR, 32'h100_0000);
    send_reading(-16'sd4321);
    write_reg(REG_MEAS_ERROR, 32'd1);
    send_reading(16'sd77);
  endtask

  task automatic test_random_phases();
    logic signed [READ_W-1:0] rd;
    logic signed [READ_W-1:0] centre;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_NOISE_SCALE, 32'd65536);
          write_reg(REG_MEAS_ERROR, 32'd65536);
          write_reg(REG_SENSOR_SPAN, 32'd65535);
        end
        1: begin
          write_reg(REG_NOISE_SCALE, 32'hFF_FFFF);
          write_reg(REG_MEAS_ERROR, 32'd1);
          write_reg(REG_SENSOR_SPAN, 32'd1);
        end
        2: begin
          write_reg(REG_NOISE_SCALE, 32'd0);
          write_reg(REG_MEAS_ERROR, 32'h100_0000);
          write_reg(REG_SENSOR_SPAN, 32'd0);
        end
        default: begin
          write_reg(REG_NOISE_SCALE, $urandom_range(0, 32'hFF_FFFF));
          write_reg(REG_MEAS_ERROR, $urandom_range(0, 32'h1FF_FFFF));
          write_reg(REG_SENSOR_SPAN, $urandom_range(0, 32'hFFFF));
        end
      endcase
      write_reg(REG_INIT_EST, $urandom());
      centre = 16'($urandom());
      for (int i = 0; i < 80; i++) begin
        // Mostly a noisy signal around a level, sometimes a wild sample.
        if ($urandom_range(0, 3) == 0) rd = 16'($urandom());
        else rd = centre + $signed(16'($urandom_range(0, 64))) - 16'sd32;
        send_reading(rd);
        if (ph == 3 && i == 40) wait_drained();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_NOISE_SCALE;
    cfg_data <= '0;
    mismatches = 0;
    scale_q = 24'd65536;
    meas_var_q = 25'd65536;
    span_q = 16'd65535;
    est_prev_q = '0;
    out_last_q = '0;
    cov_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_initial_estimate();
    test_special_cases();
    test_random_phases();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("adaptive_scalar_kalman_filter test passed");
    end else begin
      $display("adaptive_scalar_kalman_filter test failed");
    end
    $finish;
  end

  // Guards against a hang.
  initial begin
    #20ms;
    $display("adaptive_scalar_kalman_filter test failed");
    $finish;
  end

endmodule
